// ===== sv/lcg_pkg.sv =====
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared types and constants for the line color gradient core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lcg_pkg;

   localparam int CH_W    = 8;
   localparam int NUM_CH  = 3;
   localparam int COLOR_W = CH_W * NUM_CH;
   localparam int DIFF_W  = CH_W + 1;
   localparam int RSP_W   = 32;
   localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

   typedef struct packed {
      logic              valid;
      logic              bypass;
      logic [NUM_CH-1:0] neg;
   } ctl_type;

endpackage

`default_nettype wire

// ===== sv/lcg_front.sv =====
// ----------------------------------------------------------------------------
// lcg_front
// Axis select, span normalization and per-channel product, two stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcg_front #(
   parameter int COORD_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  en,
   input  wire                                  in_valid,
   input  wire  [8*COORD_BITS+71:0]             in_data,
   output lcg_pkg::ctl_type                     ctl_out,
   output logic [COORD_BITS-1:0]                den_out,
   output logic [lcg_pkg::COLOR_W-1:0]          base_out,
   output logic [lcg_pkg::NUM_CH-1:0][COORD_BITS+7:0] mag_out
);

   localparam int CB  = COORD_BITS;
   localparam int PW  = CB + 1;
   localparam int PRW = PW + lcg_pkg::DIFF_W;
   localparam int M   = CB + 8;

   logic signed [CB-1:0] cur_x, cur_y, start_x, start_y, end_x, end_y;
   logic [CB-1:0] delta_x, delta_y;
   logic [lcg_pkg::COLOR_W-1:0] cur_color, start_color, end_color;

   assign cur_x       = in_data[CB-1:0];
   assign cur_y       = in_data[2*CB-1:CB];
   assign cur_color   = in_data[2*CB+23:2*CB];
   assign start_x     = in_data[3*CB+23:2*CB+24];
   assign start_y     = in_data[4*CB+23:3*CB+24];
   assign start_color = in_data[4*CB+47:4*CB+24];
   assign end_x       = in_data[5*CB+47:4*CB+48];
   assign end_y       = in_data[6*CB+47:5*CB+48];
   assign end_color   = in_data[6*CB+71:6*CB+48];
   assign delta_x     = in_data[7*CB+71:6*CB+72];
   assign delta_y     = in_data[8*CB+71:7*CB+72];

   // stage A
   logic                 a_valid_ff, a_bypass_ff;
   logic                 a_bypass_in;
   logic signed [PW-1:0] a_place_ff, a_place_in;
   logic [CB-1:0]        a_den_ff, a_den_in;
   logic [lcg_pkg::COLOR_W-1:0] a_base_ff, a_base_in;
   logic [lcg_pkg::NUM_CH-1:0][lcg_pkg::DIFF_W-1:0] a_diff_ff, a_diff_in;

   logic signed [PW-1:0] cs, cc, ce, place, span, span_n;

   always_comb begin
      if (delta_x > delta_y) begin
         cs = PW'(start_x);
         cc = PW'(cur_x);
         ce = PW'(end_x);
      end else begin
         cs = PW'(start_y);
         cc = PW'(cur_y);
         ce = PW'(end_y);
      end
      place  = cc - cs;
      span   = ce - cs;
      span_n = -span;
      if (span < 0) begin
         a_place_in = -place;
         a_den_in   = span_n[CB-1:0];
      end else begin
         a_place_in = place;
         a_den_in   = span[CB-1:0];
      end
      a_bypass_in = (cur_color == end_color) || (span == '0);
      a_base_in   = a_bypass_in ? end_color : start_color;
      for (int c = 0; c < lcg_pkg::NUM_CH; c++) begin
         a_diff_in[c] = {1'b0, end_color[c*lcg_pkg::CH_W +: lcg_pkg::CH_W]}
                      - {1'b0, start_color[c*lcg_pkg::CH_W +: lcg_pkg::CH_W]};
      end
   end

   // stage B
   logic                 b_valid_ff, b_bypass_ff;
   logic [lcg_pkg::NUM_CH-1:0] b_neg_ff, b_neg_in;
   logic [CB-1:0]        b_den_ff;
   logic [lcg_pkg::COLOR_W-1:0] b_base_ff;
   logic [lcg_pkg::NUM_CH-1:0][M-1:0] b_mag_ff, b_mag_in;
   logic signed [PRW-1:0] prod [lcg_pkg::NUM_CH];
   logic signed [PRW-1:0] prod_n [lcg_pkg::NUM_CH];

   always_comb begin
      for (int c = 0; c < lcg_pkg::NUM_CH; c++) begin
         prod[c]   = PRW'($signed(a_diff_ff[c])) * PRW'(a_place_ff);
         prod_n[c] = -prod[c];
         b_neg_in[c] = prod[c][PRW-1];
         b_mag_in[c] = b_neg_in[c] ? prod_n[c][M-1:0] : prod[c][M-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         a_bypass_ff <= a_bypass_in;
         a_place_ff  <= a_place_in;
         a_den_ff    <= a_den_in;
         a_base_ff   <= a_base_in;
         a_diff_ff   <= a_diff_in;
         b_bypass_ff <= a_bypass_ff;
         b_neg_ff    <= b_neg_in;
         b_den_ff    <= a_den_ff;
         b_base_ff   <= a_base_ff;
         b_mag_ff    <= b_mag_in;
      end
   end

   assign ctl_out.valid  = b_valid_ff;
   assign ctl_out.bypass = b_bypass_ff;
   assign ctl_out.neg    = b_neg_ff;
   assign den_out        = b_den_ff;
   assign base_out       = b_base_ff;
   assign mag_out        = b_mag_ff;

endmodule

`default_nettype wire

// ===== sv/lcg_div_cell.sv =====
// ----------------------------------------------------------------------------
// lcg_div_cell
// One restoring division step for all three channels, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcg_div_cell #(
   parameter int COORD_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   en,
   input  lcg_pkg::ctl_type                      ctl_in,
   input  wire  [COORD_BITS-1:0]                 den_in,
   input  wire  [lcg_pkg::COLOR_W-1:0]           base_in,
   input  wire  [lcg_pkg::NUM_CH-1:0][COORD_BITS-1:0] rem_in,
   input  wire  [lcg_pkg::NUM_CH-1:0][COORD_BITS+7:0] dvd_in,
   output lcg_pkg::ctl_type                      ctl_out,
   output logic [COORD_BITS-1:0]                 den_out,
   output logic [lcg_pkg::COLOR_W-1:0]           base_out,
   output logic [lcg_pkg::NUM_CH-1:0][COORD_BITS-1:0] rem_out,
   output logic [lcg_pkg::NUM_CH-1:0][COORD_BITS+7:0] dvd_out
);

   localparam int CB = COORD_BITS;
   localparam int M  = CB + 8;

   lcg_pkg::ctl_type ctl_ff;
   logic [CB-1:0] den_ff;
   logic [lcg_pkg::COLOR_W-1:0] base_ff;
   logic [lcg_pkg::NUM_CH-1:0][CB-1:0] rem_ff, rem_in_n;
   logic [lcg_pkg::NUM_CH-1:0][M-1:0]  dvd_ff, dvd_in_n;
   logic [CB:0] trial [lcg_pkg::NUM_CH];
   logic [CB:0] diff  [lcg_pkg::NUM_CH];
   logic        ge    [lcg_pkg::NUM_CH];

   always_comb begin
      for (int c = 0; c < lcg_pkg::NUM_CH; c++) begin
         trial[c] = {rem_in[c], dvd_in[c][M-1]};
         diff[c]  = trial[c] - {1'b0, den_in};
         ge[c]    = trial[c] >= {1'b0, den_in};
         rem_in_n[c] = ge[c] ? diff[c][CB-1:0] : trial[c][CB-1:0];
         dvd_in_n[c] = {dvd_in[c][M-2:0], ge[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.bypass <= ctl_in.bypass;
         ctl_ff.neg    <= ctl_in.neg;
         den_ff        <= den_in;
         base_ff       <= base_in;
         rem_ff        <= rem_in_n;
         dvd_ff        <= dvd_in_n;
      end
   end

   assign ctl_out  = ctl_ff;
   assign den_out  = den_ff;
   assign base_out = base_ff;
   assign rem_out  = rem_ff;
   assign dvd_out  = dvd_ff;

endmodule

`default_nettype wire

// ===== sv/lcg_back.sv =====
// ----------------------------------------------------------------------------
// lcg_back
// Floor correction, offset, saturation, output register and skid stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcg_back #(
   parameter int COORD_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   output logic                                  en,
   input  lcg_pkg::ctl_type                      ctl_in,
   input  wire  [lcg_pkg::COLOR_W-1:0]           base_in,
   input  wire  [lcg_pkg::NUM_CH-1:0][COORD_BITS-1:0] rem_in,
   input  wire  [lcg_pkg::NUM_CH-1:0][COORD_BITS+7:0] quo_in,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [lcg_pkg::RSP_W-1:0]             rsp_tdata
);

   localparam int CB = COORD_BITS;
   localparam int M  = CB + 8;
   localparam int SW = M + 3;

   logic [lcg_pkg::COLOR_W-1:0] color;
   logic                        clip;
   logic [M:0]                  qm [lcg_pkg::NUM_CH];
   logic signed [SW-1:0]        qs [lcg_pkg::NUM_CH];

   always_comb begin
      clip = 1'b0;
      for (int c = 0; c < lcg_pkg::NUM_CH; c++) begin
         qm[c] = {1'b0, quo_in[c]}
               + (M+1)'(ctl_in.neg[c] && (rem_in[c] != '0));
         qs[c] = $signed(SW'(base_in[c*lcg_pkg::CH_W +: lcg_pkg::CH_W]))
               + (ctl_in.neg[c] ? -$signed(SW'(qm[c])) : $signed(SW'(qm[c])));
         if (qs[c] < 0) begin
            color[c*lcg_pkg::CH_W +: lcg_pkg::CH_W] = '0;
            clip = 1'b1;
         end else if (qs[c] > $signed(SW'(lcg_pkg::CH_MAX))) begin
            color[c*lcg_pkg::CH_W +: lcg_pkg::CH_W] = lcg_pkg::CH_MAX;
            clip = 1'b1;
         end else begin
            color[c*lcg_pkg::CH_W +: lcg_pkg::CH_W] = qs[c][lcg_pkg::CH_W-1:0];
         end
      end
      if (ctl_in.bypass) begin
         color = base_in;
         clip  = 1'b0;
      end
   end

   logic [lcg_pkg::RSP_W-1:0] result;
   assign result = {{(lcg_pkg::RSP_W-lcg_pkg::COLOR_W-1){1'b0}}, clip, color};

   logic                      out_valid_ff, out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   logic [lcg_pkg::RSP_W-1:0] out_data_ff, out_data_in;
   logic [lcg_pkg::RSP_W-1:0] skid_data_ff, skid_data_in;
   logic                      arrive;

   assign en     = !skid_valid_ff;
   assign arrive = en && ctl_in.valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = skid_valid_ff;
         out_data_in  = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (arrive) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

// ===== sv/line_color_gradient_core.sv =====
// ----------------------------------------------------------------------------
// line_color_gradient_core
// Per-pixel linear RGB interpolation along a line segment.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel transaction: its position and color, the line's
//   end points and colors, and the per-axis extents. rsp_* returns one
//   transaction per request: the interpolated color and a saturation flag.
//   A new request is taken every cycle that req_tready is high; throughput
//   is one pixel per clock unless the pipeline freezes. A request passes
//   through two front stages (axis select, then the channel products),
//   COORD_BITS + 8 divider cells that each resolve one quotient bit for all
//   three channels, and the output register. The cell chain sets the latency.
//   Reset clears all valid flags; no response is pending afterwards.
//   When the receiver stalls, the output register holds its transaction and
//   a skid stage takes the next; once the skid stage is full the pipeline
//   freezes and req_tready drops until the output drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_color_gradient_core #(
   parameter int COORD_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // cur_x, cur_y, cur_color, start_x, start_y, start_color,
   // end_x, end_y, end_color, delta_x, delta_y
   input  wire  [8*COORD_BITS+71:0]     req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // pixel_color, clipped, zero fill
   output logic [lcg_pkg::RSP_W-1:0]    rsp_tdata
);

   localparam int CB = COORD_BITS;
   localparam int M  = CB + 8;

   logic en;

   lcg_pkg::ctl_type            ctl  [M+1];
   logic [CB-1:0]               den  [M+1];
   logic [lcg_pkg::COLOR_W-1:0] base [M+1];
   logic [lcg_pkg::NUM_CH-1:0][CB-1:0] rem [M+1];
   logic [lcg_pkg::NUM_CH-1:0][M-1:0]  dvd [M+1];

   assign req_tready = en;
   assign rem[0]     = '0;

   lcg_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .ctl_out  (ctl[0]),
      .den_out  (den[0]),
      .base_out (base[0]),
      .mag_out  (dvd[0])
   );

   for (genvar i = 0; i < M; i++) begin : g_cell
      lcg_div_cell #(.COORD_BITS(COORD_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .ctl_in   (ctl[i]),
         .den_in   (den[i]),
         .base_in  (base[i]),
         .rem_in   (rem[i]),
         .dvd_in   (dvd[i]),
         .ctl_out  (ctl[i+1]),
         .den_out  (den[i+1]),
         .base_out (base[i+1]),
         .rem_out  (rem[i+1]),
         .dvd_out  (dvd[i+1])
      );
   end

   lcg_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .ctl_in     (ctl[M]),
      .base_in    (base[M]),
      .rem_in     (rem[M]),
      .quo_in     (dvd[M]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   logic unused_den;
   assign unused_den = ^den[M];

endmodule

`default_nettype wire

// ===== sv/lcg_checker.sv =====
// ----------------------------------------------------------------------------
// lcg_checker
// Port-level checks for the line color gradient core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcg_checker #(
   parameter int COORD_BITS = 16
) (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_tvalid,
   input wire                       req_tready,
   input wire [8*COORD_BITS+71:0]   req_tdata,
   input wire                       rsp_tvalid,
   input wire                       rsp_tready,
   input wire [lcg_pkg::RSP_W-1:0]  rsp_tdata
);

   logic unused_req;
   assign unused_req = req_tvalid ^ (^req_tdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[lcg_pkg::RSP_W-1:lcg_pkg::COLOR_W+1] == '0)
      else $error("response fill bits not zero");

   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid) && !$past(rsp_tready))
      else $error("request side stalled without a stalled response");

endmodule

bind line_color_gradient_core lcg_checker #(.COORD_BITS(COORD_BITS)) u_lcg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
